// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CRT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/crt_pkg.sv =====
// ---------------------------------------------------------------------------
// crt_pkg
// shared constants and types of the chunk reassembly tracker
// ---------------------------------------------------------------------------
package crt_pkg;

	// header layout and limits
	localparam int MAX_CHUNKS_DEF    = 1024;
	localparam int CHUNK_PAYLOAD_MAX = 1800;
	localparam int HEADER_BYTES      = 28;
	localparam int FORMAT_ONE        = 1;

	// bitmap memory rows
	localparam int ROW_W   = 32;
	localparam int ROW_LSB = $clog2(ROW_W);

	// copy offset widths
	localparam int OFF_W  = 16 + $clog2(CHUNK_PAYLOAD_MAX + 1);
	localparam int COPY_W = 27;

	// config address width (four 32-bit registers)
	localparam int PADDR_W = 4;

	typedef enum logic [3:0] {
		ST_SHORT     = 4'd0,
		ST_TARGET    = 4'd1,
		ST_VERSION   = 4'd2,
		ST_STALE     = 4'd3,
		ST_MALFORMED = 4'd4,
		ST_META_DROP = 4'd5,
		ST_RANGE     = 4'd6,
		ST_ACCEPTED  = 4'd7,
		ST_COMPLETE  = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		REG_LOCAL_PLAYER  = 2'd0,
		REG_CURRENT_LEVEL = 2'd1,
		REG_SECRET_LEVEL  = 2'd2,
		REG_MAP_SEED      = 2'd3
	} reg_idx_t;

	// bitmap update command
	typedef struct packed {
		logic wr;
		logic clr_all;
	} map_cmd_t;

endpackage

// ===== rtl/crt_seen_map.sv =====
// ---------------------------------------------------------------------------
// crt_seen_map
// seen-chunk bitmap: row memory with per-row valid bits for instant clearing
// ---------------------------------------------------------------------------
module crt_seen_map #(
	parameter int ROWS   = 32,
	parameter int ROW_AW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [ROW_AW-1:0]         rd_addr,
	output logic [crt_pkg::ROW_W-1:0] rd_bits,
	input  crt_pkg::map_cmd_t         cmd,
	input  logic [ROW_AW-1:0]         wr_addr,
	input  logic [crt_pkg::ROW_W-1:0] wr_data
);

	logic [crt_pkg::ROW_W-1:0] mem [ROWS];
	logic [ROWS-1:0]           row_vld_q;
	logic [crt_pkg::ROW_W-1:0] rd_row_q;
	logic                      rd_vld_q;

	// row memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	// row valid bits: a write marks its own row, a clear drops all other rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			for (int r = 0; r < ROWS; r++) begin
				if (cmd.wr && (wr_addr == ROW_AW'(r))) begin
					row_vld_q[r] <= 1'b1;
				end else if (cmd.clr_all) begin
					row_vld_q[r] <= 1'b0;
				end
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// a row never written since the last clear reads as empty
	assign rd_bits = rd_vld_q ? rd_row_q : '0;

endmodule

// ===== rtl/chunk_reassembly_tracker.sv =====
// ---------------------------------------------------------------------------
// chunk_reassembly_tracker
// checks snapshot chunk headers and tracks the chunks of the current transfer
// ---------------------------------------------------------------------------
// Each header word is handled in an accept cycle and a finish step: in the
// accept cycle the header checks are registered and the bitmap row of the
// chunk is read from the seen-chunk memory; in the finish step the row is
// modified, written back and the result word is loaded into the output
// register, after which the next header is taken. A stalled output holds
// the finish step until the register is free. The bitmap is cleared at once
// via per-row valid bits, so reset and transfer drops need no clearing pass.
`include "assert_macros.svh"

module chunk_reassembly_tracker #(
	parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [crt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// header channel
	input  logic                        hdr_valid,
	output logic                        hdr_stall,
	input  logic [15:0]                 packet_length,
	input  logic [7:0]                  target_player,
	input  logic [7:0]                  format_version,
	input  logic signed [7:0]           chunk_level,
	input  logic [7:0]                  chunk_secret,
	input  logic [31:0]                 chunk_seed,
	input  logic [15:0]                 transfer_id,
	input  logic [15:0]                 chunk_index,
	input  logic [15:0]                 chunk_count,
	input  logic [31:0]                 total_bytes,
	input  logic [31:0]                 snapshot_checksum,
	input  logic [15:0]                 payload_bytes,
	// result channel
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [3:0]                  status,
	output logic                        new_transfer,
	output logic [crt_pkg::COPY_W-1:0]  copy_offset,
	output logic [15:0]                 chunks_received
);

	localparam int ROWS   = (MAX_CHUNKS + crt_pkg::ROW_W - 1) / crt_pkg::ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int OFF_W  = crt_pkg::OFF_W;
	localparam logic [OFF_W-1:0] CPM_V = OFF_W'(crt_pkg::CHUNK_PAYLOAD_MAX);

	// config registers
	logic [7:0]        local_player_q;
	logic signed [7:0] current_level_q;
	logic              secret_level_q;
	logic [31:0]       map_seed_q;
	crt_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;

	// transfer state
	logic        active_q;
	logic [7:0]  held_level_q;
	logic        held_secret_q;
	logic [31:0] held_seed_q;
	logic [15:0] held_tid_q;
	logic [15:0] held_count_q;
	logic [31:0] held_total_q;
	logic [31:0] held_csum_q;
	logic [15:0] seen_q;

	// stage 1 registers
	logic                         busy_q;
	logic                         rej_s1;
	crt_pkg::status_t             rej_code_s1;
	logic [7:0]                   level_s1;
	logic                         secret_s1;
	logic [31:0]                  seed_s1;
	logic [15:0]                  tid_s1;
	logic [15:0]                  count_s1;
	logic [31:0]                  total_s1;
	logic [31:0]                  csum_s1;
	logic [15:0]                  payload_s1;
	logic [OFF_W-1:0]             offset_s1;
	logic [ROW_AW-1:0]            row_s1;
	logic [crt_pkg::ROW_LSB-1:0]  bit_s1;

	// output register
	logic                         out_vld_q;
	crt_pkg::status_t             status_q;
	logic                         new_q;
	logic [crt_pkg::COPY_W-1:0]   offset_q;
	logic [15:0]                  cnt_q;

	// handshake and checks
	logic             hdr_acc;
	logic             finish;
	logic             c_short;
	logic             c_target;
	logic             c_version;
	logic             c_stale;
	logic             c_malformed;
	crt_pkg::status_t rej_code;

	// finish-step evaluation
	logic [crt_pkg::ROW_W-1:0] rd_bits;
	logic [crt_pkg::ROW_W-1:0] wr_row;
	crt_pkg::map_cmd_t         map_cmd;
	logic                      fresh;
	logic                      meta_bad;
	logic                      range_bad;
	logic                      seen_bit;
	logic [15:0]               new_seen;
	logic [15:0]               count_eff;
	logic [31:0]               total_eff;
	logic                      complete;
	logic [32:0]               end_byte;
	crt_pkg::status_t          st;
	logic                      clear_all;
	logic                      take;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = crt_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_player_q  <= '0;
			current_level_q <= '0;
			secret_level_q  <= 1'b0;
			map_seed_q      <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				crt_pkg::REG_LOCAL_PLAYER:  local_player_q  <= pwdata[7:0];
				crt_pkg::REG_CURRENT_LEVEL: current_level_q <= pwdata[7:0];
				crt_pkg::REG_SECRET_LEVEL:  secret_level_q  <= pwdata[0];
				crt_pkg::REG_MAP_SEED:      map_seed_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			crt_pkg::REG_LOCAL_PLAYER:  prdata = {24'b0, local_player_q};
			crt_pkg::REG_CURRENT_LEVEL: prdata = {24'b0, current_level_q};
			crt_pkg::REG_SECRET_LEVEL:  prdata = {31'b0, secret_level_q};
			crt_pkg::REG_MAP_SEED:      prdata = map_seed_q;
			default:                    prdata = '0;
		endcase
	end

	// one header in flight; the next waits until the row is written back
	assign hdr_stall = busy_q;
	assign hdr_acc   = hdr_valid && !busy_q;
	assign finish    = busy_q && (!out_vld_q || !res_stall);

	// header checks, in priority order
	always_comb begin
		c_short   = packet_length < 16'(crt_pkg::HEADER_BYTES);
		c_target  = target_player != local_player_q;
		c_version = format_version != 8'(crt_pkg::FORMAT_ONE);
		c_stale   = (chunk_level != current_level_q)
			|| ((chunk_secret != 8'd0) != secret_level_q)
			|| (chunk_seed != map_seed_q);
		c_malformed = (chunk_count == 16'd0) || (chunk_index >= chunk_count)
			|| ({1'b0, chunk_count} > 17'(MAX_CHUNKS))
			|| ({1'b0, packet_length} != 17'(crt_pkg::HEADER_BYTES) + {1'b0, payload_bytes});
		if (c_short) begin
			rej_code = crt_pkg::ST_SHORT;
		end else if (c_target) begin
			rej_code = crt_pkg::ST_TARGET;
		end else if (c_version) begin
			rej_code = crt_pkg::ST_VERSION;
		end else if (c_stale) begin
			rej_code = crt_pkg::ST_STALE;
		end else begin
			rej_code = crt_pkg::ST_MALFORMED;
		end
	end

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (hdr_acc) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_acc) begin
			rej_s1      <= c_short || c_target || c_version || c_stale || c_malformed;
			rej_code_s1 <= rej_code;
			level_s1    <= chunk_level;
			secret_s1   <= chunk_secret != 8'd0;
			seed_s1     <= chunk_seed;
			tid_s1      <= transfer_id;
			count_s1    <= chunk_count;
			total_s1    <= total_bytes;
			csum_s1     <= snapshot_checksum;
			payload_s1  <= payload_bytes;
			offset_s1   <= OFF_W'(chunk_index) * CPM_V;
			row_s1      <= ROW_AW'(chunk_index >> crt_pkg::ROW_LSB);
			bit_s1      <= chunk_index[crt_pkg::ROW_LSB-1:0];
		end
	end

	// bitmap memory, read in the accept cycle
	crt_seen_map #(
		.ROWS   (ROWS),
		.ROW_AW (ROW_AW)
	) u_seen_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (hdr_acc),
		.rd_addr (ROW_AW'(chunk_index >> crt_pkg::ROW_LSB)),
		.rd_bits (rd_bits),
		.cmd     (map_cmd),
		.wr_addr (row_s1),
		.wr_data (wr_row)
	);

	// transfer identity, metadata, range and count evaluation
	always_comb begin
		fresh = !active_q || (held_tid_q != tid_s1) || (held_level_q != level_s1)
			|| (held_secret_q != secret_s1) || (held_seed_q != seed_s1);
		meta_bad = !fresh && ((held_count_q != count_s1) || (held_total_q != total_s1)
			|| (held_csum_q != csum_s1));
		total_eff = fresh ? total_s1 : held_total_q;
		count_eff = fresh ? count_s1 : held_count_q;
		end_byte  = 33'(offset_s1) + 33'(payload_s1);
		range_bad = end_byte > {1'b0, total_eff};
		seen_bit  = !fresh && rd_bits[bit_s1];
		new_seen  = (fresh ? 16'd0 : seen_q) + {15'b0, !seen_bit};
		complete  = new_seen == count_eff;
		wr_row    = (fresh ? '0 : rd_bits) | (crt_pkg::ROW_W'(1) << bit_s1);

		if (rej_s1) begin
			st = rej_code_s1;
		end else if (meta_bad) begin
			st = crt_pkg::ST_META_DROP;
		end else if (range_bad) begin
			st = crt_pkg::ST_RANGE;
		end else if (complete) begin
			st = crt_pkg::ST_COMPLETE;
		end else begin
			st = crt_pkg::ST_ACCEPTED;
		end

		take      = finish && (st == crt_pkg::ST_ACCEPTED);
		clear_all = finish && !rej_s1 && (fresh || st != crt_pkg::ST_ACCEPTED);
		map_cmd.wr      = take;
		map_cmd.clr_all = clear_all;
	end

	// transfer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			held_level_q  <= '0;
			held_secret_q <= 1'b0;
			held_seed_q   <= '0;
			held_tid_q    <= '0;
			held_count_q  <= '0;
			held_total_q  <= '0;
			held_csum_q   <= '0;
			seen_q        <= '0;
		end else if (take) begin
			active_q      <= 1'b1;
			held_level_q  <= level_s1;
			held_secret_q <= secret_s1;
			held_seed_q   <= seed_s1;
			held_tid_q    <= tid_s1;
			held_count_q  <= count_s1;
			held_total_q  <= total_s1;
			held_csum_q   <= csum_s1;
			seen_q        <= new_seen;
		end else if (clear_all) begin
			active_q      <= 1'b0;
			held_level_q  <= '0;
			held_secret_q <= 1'b0;
			held_seed_q   <= '0;
			held_tid_q    <= '0;
			held_count_q  <= '0;
			held_total_q  <= '0;
			held_csum_q   <= '0;
			seen_q        <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (finish) begin
			out_vld_q <= 1'b1;
		end else if (!res_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= st;
			if (rej_s1) begin
				new_q    <= 1'b0;
				offset_q <= '0;
				cnt_q    <= seen_q;
			end else if (meta_bad) begin
				new_q    <= 1'b0;
				offset_q <= '0;
				cnt_q    <= '0;
			end else if (range_bad) begin
				new_q    <= fresh;
				offset_q <= crt_pkg::COPY_W'(offset_s1);
				cnt_q    <= '0;
			end else begin
				new_q    <= fresh;
				offset_q <= crt_pkg::COPY_W'(offset_s1);
				cnt_q    <= new_seen;
			end
		end
	end

	assign res_valid       = out_vld_q;
	assign status          = status_q;
	assign new_transfer    = new_q;
	assign copy_offset     = offset_q;
	assign chunks_received = cnt_q;

	// checks on the tracker state
	`CRT_ASSERT_IMP(a_idle_empty, !active_q, seen_q == 16'd0)
	`CRT_ASSERT_IMP(a_count_bound, active_q, seen_q <= held_count_q)
	`CRT_ASSERT_NXT(a_done_loads_out, finish, res_valid && !busy_q)
	`CRT_ASSERT_NXT(a_complete_clears, finish && st == crt_pkg::ST_COMPLETE,
		!active_q && seen_q == 16'd0)

endmodule
